// ===== sv/sda_pkg.sv =====
// sda_pkg: shared widths, status codes, job word and sequencer types
// for the strong decay accumulator. No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package sda_pkg;

  // signal capacity and field widths
  localparam int MAX_SAMPLES = 65536;
  localparam int SAMPLE_W    = 16;
  localparam int MAG_W       = 16;
  localparam int CNT_W       = 17;
  localparam int IDX_W       = 16;
  localparam int ENERGY_W    = 47;
  localparam int MAG_SUM_W   = 32;
  localparam int WSUM_W      = 48;
  localparam int SR_W        = 18;
  localparam int VALUE_W     = 48;
  localparam int STATUS_W    = 2;

  localparam logic [SR_W-1:0] SR_RESET = 18'd44100;

  // configuration port
  localparam int PADDR_W     = 3;
  localparam int PDATA_W     = 32;
  localparam int CFG_IDX_BIT = 2;
  localparam logic CFG_IDX_SAMPLE_RATE = 1'b0;

  // back end datapath widths
  localparam int MUL_W   = 32;
  localparam int PROD_W  = 79;   // energy * magnitude
  localparam int NUM_W   = 98;   // numerator, padded to an even width
  localparam int ROOT_W  = NUM_W / 2;
  localparam int REM_W   = 51;
  localparam int ITER_W  = $clog2(NUM_W);

  // job queue
  localparam int JOB_DEPTH = 2;
  localparam int JOB_PTR_W = $clog2(JOB_DEPTH);
  localparam int JOB_CNT_W = $clog2(JOB_DEPTH + 1);

  typedef enum logic [STATUS_W-1:0] {
    STS_OK          = 2'd0,
    STS_TOO_SHORT   = 2'd1,
    STS_ZERO_SIGNAL = 2'd2,
    STS_TOO_LONG    = 2'd3
  } status_t;

  typedef struct packed {
    logic [ENERGY_W-1:0]  energy;
    logic [MAG_SUM_W-1:0] magnitude;
    logic [WSUM_W-1:0]    weighted;
    status_t              status;
  } job_t;

  typedef enum logic [2:0] {
    BS_IDLE,
    BS_MUL,
    BS_ACC,
    BS_DIV,
    BS_SQRT,
    BS_DONE
  } back_state_t;

  // partial products of energy * magnitude * sample_rate
  typedef enum logic [2:0] {
    MS_ELO,
    MS_EHI,
    MS_PLO,
    MS_PMID,
    MS_PHI
  } mul_step_t;

endpackage
`default_nettype wire

// ===== sv/sda_front.sv =====
// sda_front: takes one sample a cycle while full is low, keeps the running sums
// and count, and hands a finished signal to the job queue. Depends on sda_pkg.
`timescale 1ns / 1ps
`default_nettype none
module sda_front (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           push,
  output logic                                full,
  input  wire logic signed [sda_pkg::SAMPLE_W-1:0] in_sample,
  input  wire logic                           in_last,
  input  wire logic [sda_pkg::JOB_CNT_W-1:0]  job_count,
  output logic                                job_push,
  output sda_pkg::job_t                       job_data
);

  logic                           accept;
  logic [sda_pkg::SAMPLE_W-1:0]   smp_u;
  logic [sda_pkg::MAG_W-1:0]      mag;
  logic [sda_pkg::MAG_W-1:0]      mag_g;
  logic                           in_range;
  logic [sda_pkg::CNT_W-1:0]      cnt_after;
  logic [sda_pkg::JOB_CNT_W:0]    reserved;

  logic [sda_pkg::CNT_W-1:0]      count_r, count_nxt;

  logic                           s1_valid_r;
  logic                           s1_last_r;
  logic                           s1_short_r;
  logic                           s1_long_r;
  logic [sda_pkg::MAG_W-1:0]      s1_mag_r;
  logic [2*sda_pkg::MAG_W-1:0]    s1_sq_r;
  logic [2*sda_pkg::MAG_W-1:0]    s1_wp_r;

  logic [sda_pkg::ENERGY_W-1:0]   energy_r;
  logic [sda_pkg::MAG_SUM_W-1:0]  magsum_r;
  logic [sda_pkg::WSUM_W-1:0]     wsum_r;
  logic [sda_pkg::ENERGY_W-1:0]   e_tot;
  logic [sda_pkg::MAG_SUM_W-1:0]  m_tot;
  logic [sda_pkg::WSUM_W-1:0]     w_tot;

  // a last word in flight holds a queue slot, so the push below never overflows
  assign reserved = {1'b0, job_count}
                  + (sda_pkg::JOB_CNT_W + 1)'(s1_valid_r & s1_last_r);
  assign full     = reserved >= (sda_pkg::JOB_CNT_W + 1)'(sda_pkg::JOB_DEPTH);
  assign accept   = push & ~full;

  assign smp_u    = in_sample;
  assign mag      = smp_u[sda_pkg::SAMPLE_W-1] ? (~smp_u + 16'd1) : smp_u;
  assign in_range = count_r < sda_pkg::CNT_W'(sda_pkg::MAX_SAMPLES);
  assign mag_g    = in_range ? mag : '0;
  assign cnt_after = in_range ? (count_r + 17'd1)
                              : sda_pkg::CNT_W'(sda_pkg::MAX_SAMPLES + 1);

  always_comb begin
    count_nxt = count_r;
    if (accept) begin
      count_nxt = in_last ? '0 : cnt_after;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r    <= '0;
      s1_valid_r <= 1'b0;
    end else begin
      count_r    <= count_nxt;
      s1_valid_r <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_last_r  <= in_last;
      s1_short_r <= cnt_after < 17'd2;
      s1_long_r  <= cnt_after > sda_pkg::CNT_W'(sda_pkg::MAX_SAMPLES);
      s1_mag_r   <= mag_g;
      s1_sq_r    <= mag_g * mag_g;
      s1_wp_r    <= count_r[sda_pkg::IDX_W-1:0] * mag_g;
    end
  end

  assign e_tot = energy_r + sda_pkg::ENERGY_W'(s1_sq_r);
  assign m_tot = magsum_r + sda_pkg::MAG_SUM_W'(s1_mag_r);
  assign w_tot = wsum_r + sda_pkg::WSUM_W'(s1_wp_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      energy_r <= '0;
      magsum_r <= '0;
      wsum_r   <= '0;
    end else if (s1_valid_r) begin
      energy_r <= s1_last_r ? '0 : e_tot;
      magsum_r <= s1_last_r ? '0 : m_tot;
      wsum_r   <= s1_last_r ? '0 : w_tot;
    end
  end

  assign job_push = s1_valid_r & s1_last_r;

  always_comb begin
    job_data.energy    = e_tot;
    job_data.magnitude = m_tot;
    job_data.weighted  = w_tot;
    priority if (s1_short_r) begin
      job_data.status = sda_pkg::STS_TOO_SHORT;
    end else if (s1_long_r) begin
      job_data.status = sda_pkg::STS_TOO_LONG;
    end else if (w_tot == '0) begin
      job_data.status = sda_pkg::STS_ZERO_SIGNAL;
    end else begin
      job_data.status = sda_pkg::STS_OK;
    end
  end

endmodule
`default_nettype wire

// ===== sv/sda_job_fifo.sv =====
// sda_job_fifo: short queue of finished signals between the accumulating
// front and the arithmetic back end. Depends on sda_pkg.
`timescale 1ns / 1ps
`default_nettype none
module sda_job_fifo (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          push,
  input  wire sda_pkg::job_t                 wdata,
  input  wire logic                          pop,
  output sda_pkg::job_t                      rdata,
  output logic [sda_pkg::JOB_CNT_W-1:0]      count,
  output logic                               empty
);

  sda_pkg::job_t                     entry_r [sda_pkg::JOB_DEPTH];
  logic [sda_pkg::JOB_PTR_W-1:0]     wr_ptr_r, wr_ptr_nxt;
  logic [sda_pkg::JOB_PTR_W-1:0]     rd_ptr_r, rd_ptr_nxt;
  logic [sda_pkg::JOB_CNT_W-1:0]     count_r, count_nxt;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == sda_pkg::JOB_PTR_W'(sda_pkg::JOB_DEPTH - 1))
                 ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == sda_pkg::JOB_PTR_W'(sda_pkg::JOB_DEPTH - 1))
                 ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= wdata;
    end
  end

  assign rdata = entry_r[rd_ptr_r];
  assign count = count_r;
  assign empty = (count_r == '0);

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push && !pop |-> count_r < sda_pkg::JOB_CNT_W'(sda_pkg::JOB_DEPTH))
    else $error("job queue written while full");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> count_r != '0)
    else $error("job queue read while empty");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= sda_pkg::JOB_CNT_W'(sda_pkg::JOB_DEPTH))
    else $error("job queue count above depth");
`endif

endmodule
`default_nettype wire

// ===== sv/sda_back.sv =====
// sda_back: per-signal arithmetic. Forms energy*magnitude*rate with one
// shared 32x32 multiplier, divides by the weighted sum one bit a cycle,
// takes the floor square root two bits a cycle. Depends on sda_pkg.
`timescale 1ns / 1ps
`default_nettype none
module sda_back (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           job_empty,
  input  wire sda_pkg::job_t                  job_data,
  output logic                                job_pop,
  input  wire logic [sda_pkg::SR_W-1:0]       sample_rate,
  input  wire logic                           pop,
  output logic                                empty,
  output logic [sda_pkg::VALUE_W-1:0]         out_decay_value,
  output logic [sda_pkg::STATUS_W-1:0]        out_status
);

  sda_pkg::back_state_t             state_r, state_nxt;
  sda_pkg::mul_step_t               step_r, step_nxt;
  logic [sda_pkg::ITER_W-1:0]       cnt_r, cnt_nxt;
  sda_pkg::job_t                    job_r, job_nxt;
  logic [2*sda_pkg::MUL_W-1:0]      p_r, p_nxt;
  logic [sda_pkg::PROD_W-1:0]       prod_r, prod_nxt;
  logic [sda_pkg::NUM_W-1:0]        num_r, num_nxt;
  logic [sda_pkg::REM_W-1:0]        rem_r, rem_nxt;
  logic [sda_pkg::ROOT_W-1:0]       root_r, root_nxt;

  logic                             res_valid_r, res_valid_nxt;
  logic [sda_pkg::VALUE_W-1:0]      res_value_r, res_value_nxt;
  sda_pkg::status_t                 res_status_r, res_status_nxt;

  logic [sda_pkg::MUL_W-1:0]        op_a;
  logic [sda_pkg::MUL_W-1:0]        op_b;

  logic [sda_pkg::WSUM_W:0]         div_trial;
  logic [sda_pkg::WSUM_W:0]         div_w;
  logic [sda_pkg::WSUM_W:0]         div_diff;
  logic                             div_ge;

  logic [sda_pkg::REM_W+1:0]        sq_cur;
  logic [sda_pkg::REM_W+1:0]        sq_trial;
  logic [sda_pkg::REM_W+1:0]        sq_diff;
  logic                             sq_ge;

  // multiplier operands for each partial product
  always_comb begin
    unique case (step_r)
      sda_pkg::MS_ELO: begin
        op_a = job_r.energy[sda_pkg::MUL_W-1:0];
        op_b = job_r.magnitude;
      end
      sda_pkg::MS_EHI: begin
        op_a = sda_pkg::MUL_W'(job_r.energy[sda_pkg::ENERGY_W-1:sda_pkg::MUL_W]);
        op_b = job_r.magnitude;
      end
      sda_pkg::MS_PLO: begin
        op_a = prod_r[sda_pkg::MUL_W-1:0];
        op_b = sda_pkg::MUL_W'(sample_rate);
      end
      sda_pkg::MS_PMID: begin
        op_a = prod_r[2*sda_pkg::MUL_W-1:sda_pkg::MUL_W];
        op_b = sda_pkg::MUL_W'(sample_rate);
      end
      sda_pkg::MS_PHI: begin
        op_a = sda_pkg::MUL_W'(prod_r[sda_pkg::PROD_W-1:2*sda_pkg::MUL_W]);
        op_b = sda_pkg::MUL_W'(sample_rate);
      end
      default: begin
        op_a = '0;
        op_b = '0;
      end
    endcase
  end

  // restoring division step: remainder stays below the weighted sum
  assign div_trial = {rem_r[sda_pkg::WSUM_W-1:0], num_r[sda_pkg::NUM_W-1]};
  assign div_w     = {1'b0, job_r.weighted};
  assign div_ge    = div_trial >= div_w;
  assign div_diff  = div_trial - div_w;

  // digit-by-digit square root, two radicand bits per step
  assign sq_cur   = {rem_r, num_r[sda_pkg::NUM_W-1:sda_pkg::NUM_W-2]};
  assign sq_trial = {2'b00, root_r, 2'b01};
  assign sq_ge    = sq_cur >= sq_trial;
  assign sq_diff  = sq_cur - sq_trial;

  always_comb begin
    state_nxt      = state_r;
    step_nxt       = step_r;
    cnt_nxt        = cnt_r;
    job_nxt        = job_r;
    p_nxt          = p_r;
    prod_nxt       = prod_r;
    num_nxt        = num_r;
    rem_nxt        = rem_r;
    root_nxt       = root_r;
    res_valid_nxt  = res_valid_r & ~pop;
    res_value_nxt  = res_value_r;
    res_status_nxt = res_status_r;
    job_pop        = 1'b0;

    unique case (state_r)
      sda_pkg::BS_IDLE: begin
        if (!job_empty) begin
          job_pop   = 1'b1;
          job_nxt   = job_data;
          step_nxt  = sda_pkg::MS_ELO;
          state_nxt = (job_data.status == sda_pkg::STS_OK) ? sda_pkg::BS_MUL
                                                           : sda_pkg::BS_DONE;
        end
      end
      sda_pkg::BS_MUL: begin
        p_nxt     = op_a * op_b;
        state_nxt = sda_pkg::BS_ACC;
      end
      sda_pkg::BS_ACC: begin
        state_nxt = sda_pkg::BS_MUL;
        unique case (step_r)
          sda_pkg::MS_ELO: begin
            prod_nxt = sda_pkg::PROD_W'(p_r);
            step_nxt = sda_pkg::MS_EHI;
          end
          sda_pkg::MS_EHI: begin
            prod_nxt = prod_r + sda_pkg::PROD_W'({p_r, 32'd0});
            step_nxt = sda_pkg::MS_PLO;
          end
          sda_pkg::MS_PLO: begin
            num_nxt  = sda_pkg::NUM_W'(p_r);
            step_nxt = sda_pkg::MS_PMID;
          end
          sda_pkg::MS_PMID: begin
            num_nxt  = num_r + sda_pkg::NUM_W'({p_r, 32'd0});
            step_nxt = sda_pkg::MS_PHI;
          end
          sda_pkg::MS_PHI: begin
            num_nxt   = num_r + sda_pkg::NUM_W'({p_r, 64'd0});
            rem_nxt   = '0;
            cnt_nxt   = '0;
            state_nxt = sda_pkg::BS_DIV;
          end
          default: begin
            state_nxt = sda_pkg::BS_IDLE;
          end
        endcase
      end
      sda_pkg::BS_DIV: begin
        num_nxt = {num_r[sda_pkg::NUM_W-2:0], div_ge};
        rem_nxt = sda_pkg::REM_W'(div_ge ? div_diff[sda_pkg::WSUM_W-1:0]
                                         : div_trial[sda_pkg::WSUM_W-1:0]);
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == sda_pkg::ITER_W'(sda_pkg::NUM_W - 1)) begin
          rem_nxt   = '0;
          root_nxt  = '0;
          cnt_nxt   = '0;
          state_nxt = sda_pkg::BS_SQRT;
        end
      end
      sda_pkg::BS_SQRT: begin
        num_nxt  = {num_r[sda_pkg::NUM_W-3:0], 2'b00};
        root_nxt = {root_r[sda_pkg::ROOT_W-2:0], sq_ge};
        rem_nxt  = sq_ge ? sq_diff[sda_pkg::REM_W-1:0] : sq_cur[sda_pkg::REM_W-1:0];
        cnt_nxt  = cnt_r + 1'b1;
        if (cnt_r == sda_pkg::ITER_W'(sda_pkg::ROOT_W - 1)) begin
          state_nxt = sda_pkg::BS_DONE;
        end
      end
      sda_pkg::BS_DONE: begin
        if (!res_valid_r || pop) begin
          res_valid_nxt  = 1'b1;
          res_status_nxt = job_r.status;
          if (job_r.status != sda_pkg::STS_OK) begin
            res_value_nxt = '0;
          end else if (root_r[sda_pkg::ROOT_W-1]) begin
            res_value_nxt = '1;
          end else begin
            res_value_nxt = root_r[sda_pkg::VALUE_W-1:0];
          end
          state_nxt = sda_pkg::BS_IDLE;
        end
      end
      default: begin
        state_nxt = sda_pkg::BS_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= sda_pkg::BS_IDLE;
      res_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      res_valid_r <= res_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    step_r       <= step_nxt;
    cnt_r        <= cnt_nxt;
    job_r        <= job_nxt;
    p_r          <= p_nxt;
    prod_r       <= prod_nxt;
    num_r        <= num_nxt;
    rem_r        <= rem_nxt;
    root_r       <= root_nxt;
    res_value_r  <= res_value_nxt;
    res_status_r <= res_status_nxt;
  end

  assign empty           = ~res_valid_r;
  assign out_decay_value = res_value_r;
  assign out_status      = res_status_r;

`ifndef SYNTHESIS
  a_div_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == sda_pkg::BS_DIV |-> rem_r < sda_pkg::REM_W'(job_r.weighted))
    else $error("division remainder not below divisor");

  a_sqrt_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == sda_pkg::BS_SQRT |-> rem_r <= {1'b0, root_r, 1'b0})
    else $error("square root remainder above twice the partial root");

  a_error_value_zero: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid_r && res_status_r != sda_pkg::STS_OK |-> res_value_r == '0)
    else $error("error result carries a nonzero value");
`endif

endmodule
`default_nettype wire

// ===== sv/strong_decay_accumulator.sv =====
// Strong decay accumulator: sample rate register, accumulating front,
// job queue and arithmetic back end. Depends on sda_pkg, sda_front,
// sda_job_fifo and sda_back.
//
// Usage:
//   Input words (in_sample, in_last) enter on push when full is low, one per
//   cycle. A word with in_last set closes the signal and queues one result.
//   Result words (out_decay_value, out_status) wait while empty is low and
//   leave on pop. Every last word yields exactly one result, in order.
//   A good signal's last word passes through the front stages, the multiply
//   and accumulate steps for each partial product on one shared 32x32
//   multiplier, 98 division steps, 49 square root steps and 1 result write;
//   an error status skips the arithmetic. Samples stream at one per cycle
//   while full is low; the back end finishes one closed signal, through the
//   serial divider and root unit, before it takes the next. Two closed
//   signals can wait in the job queue; full rises when both slots are taken
//   or reserved. A stalled receiver holds the result register; the back end
//   then waits with its finished value, and the front keeps taking samples
//   until the queue fills. Reset clears the sums, count, queue and result,
//   and loads sample_rate with 44100. The APB port (register 0 at byte 0)
//   must be written by the user only while idle; the block does not check.
`timescale 1ns / 1ps
`default_nettype none
module strong_decay_accumulator (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           push,
  output logic                                full,
  input  wire logic signed [sda_pkg::SAMPLE_W-1:0] in_sample,
  input  wire logic                           in_last,
  output logic                                empty,
  input  wire logic                           pop,
  output logic [sda_pkg::VALUE_W-1:0]         out_decay_value,
  output logic [sda_pkg::STATUS_W-1:0]        out_status,
  input  wire logic                           psel,
  input  wire logic                           penable,
  input  wire logic                           pwrite,
  input  wire logic [sda_pkg::PADDR_W-1:0]    paddr,
  input  wire logic [sda_pkg::PDATA_W-1:0]    pwdata,
  output logic [sda_pkg::PDATA_W-1:0]         prdata,
  output logic                                pready
);

  logic [sda_pkg::SR_W-1:0]          sample_rate_r, sample_rate_nxt;
  logic                              sr_sel;

  logic                              job_push;
  sda_pkg::job_t                     job_wdata;
  logic                              job_pop;
  sda_pkg::job_t                     job_rdata;
  logic [sda_pkg::JOB_CNT_W-1:0]     job_count;
  logic                              job_empty;

  assign pready = 1'b1;
  assign sr_sel = (paddr[sda_pkg::CFG_IDX_BIT] == sda_pkg::CFG_IDX_SAMPLE_RATE);

  always_comb begin
    sample_rate_nxt = sample_rate_r;
    if (psel && penable && pwrite && pready && sr_sel) begin
      sample_rate_nxt = pwdata[sda_pkg::SR_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sample_rate_r <= sda_pkg::SR_RESET;
    end else begin
      sample_rate_r <= sample_rate_nxt;
    end
  end

  assign prdata = sr_sel ? sda_pkg::PDATA_W'(sample_rate_r) : '0;

  sda_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .full      (full),
    .in_sample (in_sample),
    .in_last   (in_last),
    .job_count (job_count),
    .job_push  (job_push),
    .job_data  (job_wdata)
  );

  sda_job_fifo u_job_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (job_push),
    .wdata (job_wdata),
    .pop   (job_pop),
    .rdata (job_rdata),
    .count (job_count),
    .empty (job_empty)
  );

  sda_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .job_empty       (job_empty),
    .job_data        (job_rdata),
    .job_pop         (job_pop),
    .sample_rate     (sample_rate_r),
    .pop             (pop),
    .empty           (empty),
    .out_decay_value (out_decay_value),
    .out_status      (out_status)
  );

endmodule
`default_nettype wire

// ===== verif/strong_decay_accumulator_tb.sv =====
// Self-checking testbench for strong_decay_accumulator: drives sample words and
// APB rate writes, predicts each signal's decay value and status, checks results.
// Depends on sda_pkg and the strong_decay_accumulator RTL.
`timescale 1ns / 1ps
module strong_decay_accumulator_tb;

  localparam int CLK_PERIOD     = 8;
  localparam int SETTLE_CYCLES  = 200;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int PHASE_WORDS    = 200;
  localparam logic [sda_pkg::PADDR_W-1:0] RATE_ADDR =
    sda_pkg::PADDR_W'(sda_pkg::CFG_IDX_SAMPLE_RATE) << sda_pkg::CFG_IDX_BIT;
  localparam logic [sda_pkg::VALUE_W-1:0] VALUE_MAX = '1;

  typedef enum int {SM_FULL, SM_SMALL, SM_EDGE, SM_MIN, SM_ZERO, SM_LEAD_ONLY} sample_mode_t;

  typedef struct {
    logic [sda_pkg::VALUE_W-1:0] value;
    sda_pkg::status_t            status;
  } decay_result_t;

  class decay_scoreboard;
    logic [sda_pkg::SR_W-1:0] rate;
    logic [63:0]     energy;
    logic [63:0]     mag_sum;
    logic [63:0]     wsum;
    int unsigned     count;
    decay_result_t   expected_q[$];
    int              errors;

    function new();
      rate    = sda_pkg::SR_RESET;
      errors  = 0;
      clear_sums();
    endfunction

    function void clear_sums();
      energy  = 0;
      mag_sum = 0;
      wsum    = 0;
      count   = 0;
    endfunction

    function void set_rate(logic [sda_pkg::PDATA_W-1:0] v);
      rate = v[sda_pkg::SR_W-1:0];
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    // floor(sqrt(e * a * rate / w)), clamped to the value width
    function logic [sda_pkg::VALUE_W-1:0] decay(logic [63:0] e, logic [63:0] a,
                                                logic [63:0] w);
      logic [127:0] quo;
      logic [127:0] root;
      logic [127:0] cand;
      quo  = (128'(e) * 128'(a) * 128'(rate)) / 128'(w);
      root = 0;
      for (int i = 49; i >= 0; i--) begin
        cand = root | (128'(1) << i);
        if (cand * cand <= quo) root = cand;
      end
      return (root > 128'(VALUE_MAX)) ? VALUE_MAX : root[sda_pkg::VALUE_W-1:0];
    endfunction

    function void note_sample(logic signed [sda_pkg::SAMPLE_W-1:0] s, logic l);
      int            v;
      logic [63:0]   m;
      decay_result_t r;
      v = s;
      m = (v < 0) ? 64'(-v) : 64'(v);
      if (count < sda_pkg::MAX_SAMPLES) begin
        energy  += m * m;
        mag_sum += m;
        wsum    += 64'(count) * m;
        count++;
      end else begin
        count = sda_pkg::MAX_SAMPLES + 1;
      end
      if (!l) return;
      r.value = '0;
      if (count < 2)                         r.status = sda_pkg::STS_TOO_SHORT;
      else if (count > sda_pkg::MAX_SAMPLES) r.status = sda_pkg::STS_TOO_LONG;
      else if (wsum == 0)                    r.status = sda_pkg::STS_ZERO_SIGNAL;
      else begin
        r.status = sda_pkg::STS_OK;
        r.value  = decay(energy, mag_sum, wsum);
      end
      expected_q.push_back(r);
      clear_sums();
    endfunction

    function void check_result(logic [sda_pkg::VALUE_W-1:0] v,
                               logic [sda_pkg::STATUS_W-1:0] st);
      decay_result_t r;
      if (expected_q.size() == 0) begin
        $error("unexpected result word: decay_value %0d status %0d", v, st);
        errors++;
        return;
      end
      r = expected_q.pop_front();
      if (v !== r.value) begin
        $error("decay_value: expected %0d, got %0d", r.value, v);
        errors++;
      end
      if (st !== r.status) begin
        $error("status: expected %0d, got %0d", r.status, st);
        errors++;
      end
    endfunction
  endclass

  logic                                clk;
  logic                                rst_n;
  logic                                push;
  logic                                full;
  logic signed [sda_pkg::SAMPLE_W-1:0] in_sample;
  logic                                in_last;
  logic                                empty;
  logic                                pop;
  logic [sda_pkg::VALUE_W-1:0]         out_decay_value;
  logic [sda_pkg::STATUS_W-1:0]        out_status;
  logic                                psel;
  logic                                penable;
  logic                                pwrite;
  logic [sda_pkg::PADDR_W-1:0]         paddr;
  logic [sda_pkg::PDATA_W-1:0]         pwdata;
  logic [sda_pkg::PDATA_W-1:0]         prdata;
  logic                                pready;

  decay_scoreboard sb = new();
  bit              send_gaps = 1;
  bit              recv_gaps = 1;
  int              sent_words = 0;
  int              quiet = 0;

  strong_decay_accumulator dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .push            (push),
    .full            (full),
    .in_sample       (in_sample),
    .in_last         (in_last),
    .empty           (empty),
    .pop             (pop),
    .out_decay_value (out_decay_value),
    .out_status      (out_status),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready)
  );

  initial clk = 1'b0;
  always #(CLK_PERIOD / 2) clk = ~clk;

  // ends the run when nothing moves for too long
  always @(posedge clk) begin
    if (!rst_n || (push && !full) || (pop && !empty) || (psel && penable)) begin
      quiet <= 0;
    end else begin
      quiet <= quiet + 1;
      if (quiet >= WATCHDOG_LIMIT) begin
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

  // result side: random stall before each pop
  initial begin
    int stall;
    pop = 1'b0;
    @(posedge rst_n);
    @(negedge clk);
    forever begin
      stall = recv_gaps ? $urandom_range(0, 13) : 0;
      if (stall > 0) begin
        pop = 1'b0;
        repeat (stall) @(negedge clk);
      end
      pop = 1'b1;
      do @(posedge clk); while (empty);
      sb.check_result(out_decay_value, out_status);
      @(negedge clk);
    end
  end

  // called at a falling edge, returns at a falling edge with push still high
  task automatic send_word(input logic signed [sda_pkg::SAMPLE_W-1:0] s, input logic l);
    int gap;
    gap = send_gaps ? $urandom_range(0, 13) : 0;
    if (gap > 0) begin
      push = 1'b0;
      repeat (gap) @(negedge clk);
    end
    push      = 1'b1;
    in_sample = s;
    in_last   = l;
    do @(posedge clk); while (full);
    sb.note_sample(s, l);
    sent_words++;
    @(negedge clk);
  endtask

  function automatic logic signed [sda_pkg::SAMPLE_W-1:0] pick_sample(sample_mode_t mode,
                                                                      int idx);
    int v;
    case (mode)
      SM_SMALL: begin
        v = $urandom_range(0, 32) - 16;
        return sda_pkg::SAMPLE_W'(v);
      end
      SM_EDGE: begin
        case ($urandom_range(0, 4))
          0: return 16'sh8000;
          1: return 16'sh7fff;
          2: return -16'sd1;
          3: return 16'sd1;
          default: return 16'sd0;
        endcase
      end
      SM_MIN:       return 16'sh8000;
      SM_ZERO:      return 16'sd0;
      SM_LEAD_ONLY: return (idx == 0) ? sda_pkg::SAMPLE_W'($urandom) : 16'sd0;
      default:      return sda_pkg::SAMPLE_W'($urandom);
    endcase
  endfunction

  task automatic send_signal(input int len, input sample_mode_t mode);
    for (int i = 0; i < len; i++)
      send_word(pick_sample(mode, i), i == len - 1);
  endtask

  task automatic send_random_signal();
    int           r;
    int           len;
    sample_mode_t mode;
    r = $urandom_range(0, 99);
    if (r < 8) begin
      len  = 1;
      mode = SM_FULL;
    end else if (r < 14) begin
      len  = $urandom_range(2, 8);
      mode = (r < 11) ? SM_ZERO : SM_LEAD_ONLY;
    end else begin
      len  = (r < 20) ? $urandom_range(30, 300) : $urandom_range(2, 16);
      mode = sample_mode_t'($urandom_range(0, 3));
    end
    send_signal(len, mode);
  endtask

  // hold the sender until every pending result is out
  task automatic drain();
    push = 1'b0;
    while (sb.pending() > 0) @(negedge clk);
  endtask

  task automatic write_rate(input logic [sda_pkg::PDATA_W-1:0] v);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = RATE_ADDR;
    pwdata  = v;
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    sb.set_rate(v);
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
  endtask

  task automatic read_rate();
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b0;
    paddr   = RATE_ADDR;
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata !== sda_pkg::PDATA_W'(sb.rate)) begin
      $error("prdata: expected %0d, got %0d", sb.rate, prdata);
      sb.errors++;
    end
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
  endtask

  // non-last words may still sit in the front pipe after the last result
  task automatic reprogram(input logic [sda_pkg::PDATA_W-1:0] v);
    drain();
    repeat (SETTLE_CYCLES) @(negedge clk);
    write_rate(v);
    read_rate();
  endtask

  initial begin
    int start;
    int r;
    bit paused;
    logic [sda_pkg::PDATA_W-1:0] rate_word;

    rst_n     = 1'b0;
    push      = 1'b0;
    in_sample = '0;
    in_last   = 1'b0;
    psel      = 1'b0;
    penable   = 1'b0;
    pwrite    = 1'b0;
    paddr     = '0;
    pwdata    = '0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // reset rate, directed corners
    read_rate();
    send_word(16'sd100, 1'b1);                  // too short
    send_word(16'sd0, 1'b0);
    send_word(16'sd0, 1'b0);
    send_word(16'sd0, 1'b1);                    // all zero
    send_word(16'sh8000, 1'b0);
    send_word(16'sd0, 1'b1);                    // energy only at index 0
    send_word(16'sh7fff, 1'b0);
    send_word(16'sh8000, 1'b1);
    send_word(16'sd0, 1'b0);
    send_word(16'sd1, 1'b1);
    send_word(-16'sd1, 1'b0);
    send_word(16'sd1, 1'b0);
    send_word(16'sh8000, 1'b0);
    send_word(16'sh7fff, 1'b1);

    reprogram(32'd1);
    send_signal(4, SM_EDGE);
    reprogram(32'd0);                           // zero rate still reports ok
    send_word(16'sd1000, 1'b0);
    send_word(-16'sd1000, 1'b0);
    send_word(16'sd3, 1'b1);

    // large sums at the widest rate
    reprogram(32'h0003_ffff);
    send_gaps = 0;
    send_signal(100, SM_MIN);
    send_signal(3, SM_FULL);
    send_gaps = 1;

    reprogram(32'd192000);
    send_signal(5, SM_FULL);
    send_signal(2, SM_MIN);
    reprogram(32'hfffc_0000 | 32'd48000);       // upper bits are dropped
    send_signal(6, SM_SMALL);

    for (int p = 0; p < 6; p++) begin
      r = $urandom_range(0, 9);
      case (r)
        0:       rate_word = 32'd1;
        1:       rate_word = 32'd192000;
        2:       rate_word = 32'h0003_ffff;
        default: rate_word = $urandom_range(1, 192000);
      endcase
      reprogram(rate_word);
      send_gaps = (p == 1 || p == 2) ? 1'b0 : (p == 0) ? 1'b1 : 1'($urandom_range(0, 1));
      recv_gaps = (p == 1) ? 1'b0 : (p == 2) ? 1'b1 : 1'($urandom_range(0, 1));
      start  = sent_words;
      paused = 0;
      while (sent_words - start < PHASE_WORDS) begin
        send_random_signal();
        if (p == 3 && !paused && sent_words - start >= PHASE_WORDS / 2) begin
          drain();
          paused = 1;
        end
      end
    end

    drain();
    repeat (SETTLE_CYCLES) @(negedge clk);
    if (sb.errors == 0 && sb.pending() == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end

endmodule
